### rtl/core/rau_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the rational arithmetic unit.
package rau_pkg;
	localparam logic [1:0] FUNC_ADD = 2'd0;
	localparam logic [1:0] FUNC_SUB = 2'd1;
	localparam logic [1:0] FUNC_MUL = 2'd2;
	localparam logic [1:0] FUNC_DIV = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	typedef enum logic [3:0] {
		OP_LOAD   = 4'b0001,
		OP_MUL    = 4'b0010,
		OP_COMB   = 4'b0100,
		OP_NONE   = 4'b1000
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [2:0] mul_sel;
		logic       gcd_start;
		logic       div_start;
		logic       fin;
	} dp_cmd_t;

	typedef struct packed {
		logic early;
		logic gcd_done;
		logic div_done;
	} dp_sts_t;
endpackage

### rtl/core/rau_divider.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, 64-bit unsigned.
module rau_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] quot,
	output logic [63:0] rem
);
	logic [63:0] q_q, r_q, d_q;
	logic [6:0]  cnt_q;
	logic        busy_q, done_q;
	logic [64:0] trial;

	assign trial = {r_q, q_q[63]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!trial[64]) begin
				r_q <= trial[63:0];
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= {r_q[62:0], q_q[63]};
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = q_q;
	assign rem  = r_q;
endmodule

### rtl/core/rau_datapath.sv
`timescale 1ns / 1ps
// Datapath: operand magnitudes, cross products, Euclid loop, final reduction.
module rau_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rau_pkg::dp_cmd_t       cmd,
	output rau_pkg::dp_sts_t       sts,
	input  logic [1:0]             func,
	input  logic signed [31:0]     a_num,
	input  logic signed [31:0]     a_den,
	input  logic signed [31:0]     b_num,
	input  logic signed [31:0]     b_den,
	output logic signed [31:0]     res_num,
	output logic [30:0]            res_den,
	output logic [1:0]             status
);
	logic [1:0]  func_q;
	logic [31:0] an_q, ad_q, bn_q, bd_q;
	logic        ans_q, ads_q, bns_q, bds_q;
	logic [63:0] p_q [0:2];
	logic        ps_q [0:2];
	logic [63:0] nm_q, dm_q, x_q, y_q;
	logic        neg_q, nz_q;
	logic [63:0] g_q, rn_q;
	logic        gcd_busy_q, gcd_done_q, phase_q;
	logic [63:0] div_a, div_b, quot, rem;
	logic        div_done;
	logic        div_start;
	logic [31:0] ma, mb;
	logic        ms;
	logic [63:0] prod;

	function automatic logic [31:0] mag(input logic [31:0] v);
		mag = v[31] ? (32'd0 - v) : v;
	endfunction

	always_comb begin
		case (cmd.mul_sel)
			3'd0: begin ma = an_q; mb = bd_q; ms = ans_q ^ bds_q; end
			3'd1: begin ma = bn_q; mb = ad_q; ms = bns_q ^ ads_q ^ (func_q == rau_pkg::FUNC_SUB); end
			3'd2: begin ma = an_q; mb = bn_q; ms = ans_q ^ bns_q; end
			3'd3: begin ma = ad_q; mb = bd_q; ms = ads_q ^ bds_q; end
			default: begin ma = ad_q; mb = bn_q; ms = ads_q ^ bns_q; end
		endcase
		prod = {32'd0, ma} * {32'd0, mb};
	end

	logic [1:0] slot;
	always_comb begin
		case (cmd.mul_sel)
			3'd0: slot = 2'd0;
			3'd1: slot = 2'd1;
			3'd2: slot = 2'd0;
			3'd3: slot = 2'd2;
			default: slot = 2'd2;
		endcase
	end

	logic [63:0] sum_m;
	logic        sum_s;
	always_comb begin
		if (ps_q[0] == ps_q[1]) begin
			sum_m = p_q[0] + p_q[1];
			sum_s = ps_q[0];
		end else if (p_q[0] >= p_q[1]) begin
			sum_m = p_q[0] - p_q[1];
			sum_s = ps_q[0];
		end else begin
			sum_m = p_q[1] - p_q[0];
			sum_s = ps_q[1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == rau_pkg::OP_LOAD) begin
			func_q <= func;
			an_q <= mag(a_num); ans_q <= a_num[31];
			ad_q <= mag(a_den); ads_q <= a_den[31];
			bn_q <= mag(b_num); bns_q <= b_num[31];
			bd_q <= mag(b_den); bds_q <= b_den[31];
		end
		if (cmd.op == rau_pkg::OP_MUL) begin
			p_q[slot]  <= prod;
			ps_q[slot] <= ms;
		end
		if (cmd.op == rau_pkg::OP_COMB) begin
			if (func_q == rau_pkg::FUNC_ADD || func_q == rau_pkg::FUNC_SUB) begin
				nm_q <= sum_m;
				neg_q <= sum_s ^ ps_q[2];
				nz_q <= (sum_m != 64'd0);
				x_q <= sum_m;
			end else begin
				nm_q <= p_q[0];
				neg_q <= ps_q[0] ^ ps_q[2];
				nz_q <= (p_q[0] != 64'd0);
				x_q <= p_q[0];
			end
			dm_q <= p_q[2];
			y_q  <= p_q[2];
		end
		if (gcd_busy_q && phase_q && div_done) begin
			x_q <= y_q;
			y_q <= rem;
		end
		if (gcd_done_q) g_q <= x_q;
		if (div_done && !gcd_busy_q) begin
			if (cmd.fin) dm_q <= quot;
			else rn_q <= quot;
		end
	end

	// gcd loop shares the divider; then two divisions by g
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gcd_busy_q <= 1'b0;
			gcd_done_q <= 1'b0;
			phase_q    <= 1'b0;
		end else begin
			gcd_done_q <= 1'b0;
			if (cmd.gcd_start) begin
				gcd_busy_q <= 1'b1;
				phase_q    <= 1'b0;
			end else if (gcd_busy_q) begin
				if (!phase_q) begin
					if (y_q == 64'd0) begin
						gcd_busy_q <= 1'b0;
						gcd_done_q <= 1'b1;
					end else begin
						phase_q <= 1'b1;
					end
				end else if (div_done) begin
					phase_q <= 1'b0;
				end
			end
		end
	end

	assign div_start = (gcd_busy_q && !phase_q && y_q != 64'd0) || cmd.div_start;
	assign div_a = gcd_busy_q ? x_q : (cmd.fin ? dm_q : nm_q);
	assign div_b = gcd_busy_q ? y_q : g_q;

	rau_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_a), .divisor(div_b),
		.done(div_done), .quot(quot), .rem(rem)
	);

	assign sts.early    = (ad_q == 32'd0) || (bd_q == 32'd0) ||
		(func_q == rau_pkg::FUNC_DIV && bn_q == 32'd0) || !nz_q;
	assign sts.gcd_done = gcd_done_q;
	assign sts.div_done = div_done && !gcd_busy_q;

	always_comb begin
		res_num = '0;
		res_den = '0;
		status  = rau_pkg::ST_OK;
		if (ad_q == 32'd0 || bd_q == 32'd0 ||
				(func_q == rau_pkg::FUNC_DIV && bn_q == 32'd0)) begin
			status = rau_pkg::ST_ZERO;
		end else if (!nz_q) begin
			res_den = 31'd1;
		end else if (dm_q > 64'h7FFF_FFFF ||
				(neg_q ? (rn_q > 64'h8000_0000) : (rn_q > 64'h7FFF_FFFF))) begin
			status = rau_pkg::ST_OVF;
		end else begin
			res_num = neg_q ? (32'd0 - rn_q[31:0]) : rn_q[31:0];
			res_den = dm_q[30:0];
		end
	end
endmodule

### rtl/core/rau_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine sequencing the datapath.
module rau_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  logic             out_taken,
	output rau_pkg::dp_cmd_t cmd,
	input  rau_pkg::dp_sts_t sts
);
	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_M0   = 10'b0000000010,
		S_M1   = 10'b0000000100,
		S_M2   = 10'b0000001000,
		S_COMB = 10'b0000010000,
		S_CHK  = 10'b0000100000,
		S_GCD  = 10'b0001000000,
		S_DN   = 10'b0010000000,
		S_DD   = 10'b0100000000,
		S_OUT  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic   go_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			go_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			go_q    <= (state_d != state_q);
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		cmd.op = rau_pkg::OP_NONE;
		cmd.mul_sel = 3'd0;
		cmd.gcd_start = 1'b0;
		cmd.div_start = 1'b0;
		cmd.fin = 1'b0;
		case (state_q)
			S_IDLE: if (in_valid) begin
				cmd.op = rau_pkg::OP_LOAD;
				state_d = S_M0;
			end
			S_M0: begin
				cmd.op = rau_pkg::OP_MUL; cmd.mul_sel = 3'd0; state_d = S_M1;
			end
			S_M1: begin
				cmd.op = rau_pkg::OP_MUL; cmd.mul_sel = 3'd1; state_d = S_M2;
			end
			S_M2: begin
				cmd.op = rau_pkg::OP_MUL; cmd.mul_sel = 3'd3; state_d = S_COMB;
			end
			S_COMB: begin
				cmd.op = rau_pkg::OP_COMB; state_d = S_CHK;
			end
			S_CHK: begin
				if (sts.early) state_d = S_OUT;
				else begin
					cmd.gcd_start = 1'b1; state_d = S_GCD;
				end
			end
			S_GCD: if (sts.gcd_done) state_d = S_DN;
			S_DN: begin
				cmd.div_start = go_q;
				if (sts.div_done) state_d = S_DD;
			end
			S_DD: begin
				cmd.fin = 1'b1;
				cmd.div_start = go_q;
				if (sts.div_done) state_d = S_OUT;
			end
			S_OUT: if (out_ready && out_taken) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end
endmodule

### rtl/core/rau_top_fix.sv
`timescale 1ns / 1ps
// Multiply-operand steering for multiply and divide operations.
module rau_top_fix (
	input  logic [1:0] func,
	input  logic [2:0] sel_in,
	output logic [2:0] sel_out
);
	always_comb begin
		if (func == rau_pkg::FUNC_MUL && sel_in == 3'd0) sel_out = 3'd2;
		else if (func == rau_pkg::FUNC_DIV && sel_in == 3'd3) sel_out = 3'd4;
		else sel_out = sel_in;
	end
endmodule

### rtl/core/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// Rational arithmetic unit: exact fraction add/sub/mul/div with gcd reduction.
// Input channel in_valid/in_ready carries func and both operand fractions;
// output channel out_valid/out_ready carries res_num, res_den and status.
// One item is worked at a time; in_ready is high only while idle, so the next
// item can be taken at the earliest in the cycle after the result transfer.
// An error or zero result skips the gcd; otherwise the work is the Euclid steps
// on the shared bit-serial 64-bit divider, the hand-over of the gcd and the two
// final divisions by it.
// The divider produces one quotient bit per cycle.
// The result is held on the outputs with out_valid high until transferred;
// a stalled receiver simply holds the block in its output state.
// Reset (arst_n low) returns the controller to idle with no result pending.
module rational_arithmetic_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic signed [31:0] a_num,
	input  logic signed [31:0] a_den,
	input  logic signed [31:0] b_num,
	input  logic signed [31:0] b_den,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] res_num,
	output logic [30:0]        res_den,
	output logic [1:0]         status
);
	rau_pkg::dp_cmd_t cmd_c, cmd_dp;
	rau_pkg::dp_sts_t sts;
	logic [1:0] func_q;
	logic [2:0] mul_sel;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) func_q <= func;
	end

	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .out_taken(1'b1),
		.cmd(cmd_c), .sts(sts)
	);

	always_comb begin
		cmd_dp = cmd_c;
		cmd_dp.mul_sel = mul_sel;
	end

	rau_top_fix u_fix (.func(func_q), .sel_in(cmd_c.mul_sel), .sel_out(mul_sel));

	rau_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_dp), .sts(sts),
		.func(func), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.res_num(res_num), .res_den(res_den), .status(status)
	);
endmodule
